[rtl/psxpal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psxpal_pkg
// Shared types, constants and the entry conversion for the palette converter.
// ----------------------------------------------------------------------------
package psxpal_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  localparam logic [15:0] BLACK_OPAQUE   = 16'h8000;
  localparam int          STP_BIT        = 15;
  localparam int          MODE_W         = 5;
  localparam int          MODE_TEST_BIT  = 4;   // 0x8000 test, low-byte alpha
  localparam int          MODE_MIXED_BIT = 0;   // alpha when stp is mixed

  // Entry read from the store, waiting for conversion
  typedef struct packed {
    logic [15:0] color;
    logic        fmt_alpha;
    logic        low_byte;
    logic        last;
  } rd_stage_t;

  // BGR555 (stp,b,g,r) -> ARGB1555 or RGB565
  function automatic logic [15:0] convert_entry(input logic [15:0] c,
                                                input logic        fmt_alpha,
                                                input logic        low_byte);
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    logic       a;
    r = c[4:0];
    g = c[9:5];
    b = c[14:10];
    a = low_byte ? (c[7:0] != 8'd0) : (c != 16'd0);
    if (fmt_alpha) begin
      return {a, r, g, b};
    end
    return {r, g, g[4], b};
  endfunction

endpackage
`default_nettype wire

[rtl/psx_palette_to_pc_color.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psx_palette_to_pc_color
// Stores a BGR555 palette, picks ARGB1555 or RGB565 at the closing entry and
// returns the converted entries in load order.
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  in        in    in_valid / in_stall     op, color_in, last_in
//  out       out   out_valid / out_stall   color_out, alpha_format, last_out
//  cfg       in    cfg_wr_en               cfg_wr_data (mode flags)
//
//  One transaction per cycle on the input while in_stall is low. An emit
//  taken reads the store into the read stage; the conversion is then
//  registered into the output once the output register can take it.
//  rst is synchronous and clears control state; store contents are kept.
//  in_stall rises only when the read stage and the output register are full
//  and out_stall is high.
// ----------------------------------------------------------------------------
module psx_palette_to_pc_color #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [psxpal_pkg::MODE_W-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        op,
  input  wire logic [15:0]                 color_in,
  input  wire logic                        last_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [15:0]                      color_out,
  output logic                             alpha_format,
  output logic                             last_out
);

  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int IDX_W = $clog2(PALETTE_DEPTH);

  logic [15:0] entry_store [PALETTE_DEPTH];

  logic [psxpal_pkg::MODE_W-1:0] mode_flags;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] read_pointer, read_pointer_next;
  logic saw_black_opaque, saw_black_opaque_next;
  logic any_stp, any_stp_next;
  logic all_stp, all_stp_next;
  logic palette_ready, palette_ready_next;
  logic fmt_alpha, fmt_alpha_next;
  logic alpha_low_byte, alpha_low_byte_next;

  psxpal_pkg::rd_stage_t rd_stage;
  logic                  rd_valid;
  logic                  rd_move;

  logic             in_acc;
  logic             load_wr;
  logic [IDX_W-1:0] wr_addr;
  logic             emit_hit;

  logic [CNT_W-1:0] base_cnt;
  logic             base_black;
  logic             base_any;
  logic             base_all;

  assign rd_move  = rd_valid && (!out_valid || !out_stall);
  assign in_stall = rd_valid && out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    entry_count_next      = entry_count;
    read_pointer_next     = read_pointer;
    saw_black_opaque_next = saw_black_opaque;
    any_stp_next          = any_stp;
    all_stp_next          = all_stp;
    palette_ready_next    = palette_ready;
    fmt_alpha_next        = fmt_alpha;
    alpha_low_byte_next   = alpha_low_byte;
    load_wr               = 1'b0;
    emit_hit              = 1'b0;

    // a load on a closed palette starts a new one
    base_cnt   = palette_ready ? '0   : entry_count;
    base_black = palette_ready ? 1'b0 : saw_black_opaque;
    base_any   = palette_ready ? 1'b0 : any_stp;
    base_all   = palette_ready ? 1'b1 : all_stp;
    wr_addr    = base_cnt[IDX_W-1:0];

    if (in_acc && psxpal_pkg::op_t'(op) == psxpal_pkg::OP_LOAD) begin
      entry_count_next      = base_cnt;
      saw_black_opaque_next = base_black;
      any_stp_next          = base_any;
      all_stp_next          = base_all;
      read_pointer_next     = palette_ready ? '0 : read_pointer;
      palette_ready_next    = 1'b0;
      if (base_cnt != CNT_W'(PALETTE_DEPTH)) begin
        load_wr          = 1'b1;
        entry_count_next = base_cnt + CNT_W'(1);
        if (color_in == psxpal_pkg::BLACK_OPAQUE) begin
          saw_black_opaque_next = 1'b1;
        end
        if (color_in[psxpal_pkg::STP_BIT]) begin
          any_stp_next = 1'b1;
        end else begin
          all_stp_next = 1'b0;
        end
      end
      if (last_in) begin
        if (mode_flags[psxpal_pkg::MODE_TEST_BIT]) begin
          alpha_low_byte_next = 1'b1;
          fmt_alpha_next      = saw_black_opaque_next;
        end else begin
          alpha_low_byte_next = 1'b0;
          fmt_alpha_next      = any_stp_next && !all_stp_next &&
                                mode_flags[psxpal_pkg::MODE_MIXED_BIT];
        end
        palette_ready_next = 1'b1;
        read_pointer_next  = '0;
      end
    end else if (in_acc && palette_ready && read_pointer < entry_count) begin
      emit_hit = 1'b1;
      if (read_pointer + CNT_W'(1) == entry_count) begin
        entry_count_next      = '0;
        read_pointer_next     = '0;
        saw_black_opaque_next = 1'b0;
        any_stp_next          = 1'b0;
        all_stp_next          = 1'b1;
        palette_ready_next    = 1'b0;
      end else begin
        read_pointer_next = read_pointer + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags       <= '0;
      entry_count      <= '0;
      read_pointer     <= '0;
      saw_black_opaque <= 1'b0;
      any_stp          <= 1'b0;
      all_stp          <= 1'b1;
      palette_ready    <= 1'b0;
      fmt_alpha        <= 1'b0;
      alpha_low_byte   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_flags <= cfg_wr_data;
      end
      entry_count      <= entry_count_next;
      read_pointer     <= read_pointer_next;
      saw_black_opaque <= saw_black_opaque_next;
      any_stp          <= any_stp_next;
      all_stp          <= all_stp_next;
      palette_ready    <= palette_ready_next;
      fmt_alpha        <= fmt_alpha_next;
      alpha_low_byte   <= alpha_low_byte_next;
    end
  end

  // palette store, read data registered with the format in force at the emit
  always_ff @(posedge clk) begin
    if (load_wr) begin
      entry_store[wr_addr] <= color_in;
    end
    if (emit_hit) begin
      rd_stage.color     <= entry_store[read_pointer[IDX_W-1:0]];
      rd_stage.fmt_alpha <= fmt_alpha;
      rd_stage.low_byte  <= alpha_low_byte;
      rd_stage.last      <= (read_pointer + CNT_W'(1) == entry_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (emit_hit) begin
      rd_valid <= 1'b1;
    end else if (rd_move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      color_out    <= psxpal_pkg::convert_entry(rd_stage.color, rd_stage.fmt_alpha,
                                                rd_stage.low_byte);
      alpha_format <= rd_stage.fmt_alpha;
      last_out     <= rd_stage.last;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (rd_valid && out_valid))
    else $error("input stalled while pipeline has room");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    palette_ready |-> (entry_count != '0 && read_pointer < entry_count))
    else $error("closed palette with no entry left to emit");

  a_idle_pointer: assert property (@(posedge clk) disable iff (rst)
    !palette_ready |-> read_pointer == '0)
    else $error("read pointer moved while palette open");

  a_emit_fills_read: assert property (@(posedge clk) disable iff (rst)
    emit_hit |=> rd_valid)
    else $error("emit lost before read stage");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(PALETTE_DEPTH))
    else $error("entry count beyond store depth");
`endif

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks psx_palette_to_pc_color: directed and random palettes are loaded
// and read back under random valid/stall gaps, and every converted entry is
// compared with a cycle-free palette predictor held in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PAL_DEPTH      = 256;
  localparam int ITEM_TARGET    = 600;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 120;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int MAX_REPORTS    = 10;
  localparam int OVERFILL_EMITS = 24;

  typedef struct packed {
    logic [15:0] color;
    logic        argb;
    logic        last;
  } pc_color_t;

  class palette_scoreboard;
    logic [15:0] entries [PAL_DEPTH];
    int unsigned n_entries;
    int unsigned rd_ptr;
    bit          saw_black;
    bit          any_stp;
    bit          all_stp;
    bit          ready;
    bit          argb;
    bit          low_byte_alpha;
    logic [psxpal_pkg::MODE_W-1:0] mode;
    pc_color_t   expected_q [$];
    int unsigned useful_items;
    int unsigned errors;

    function new();
      clear_palette();
      argb           = 1'b0;
      low_byte_alpha = 1'b0;
      mode           = '0;
      useful_items   = 0;
      errors         = 0;
    endfunction

    function void clear_palette();
      n_entries = 0;
      rd_ptr    = 0;
      saw_black = 1'b0;
      any_stp   = 1'b0;
      all_stp   = 1'b1;
      ready     = 1'b0;
    endfunction

    // Accepted input transaction: update palette state, queue any result
    function void note_item(psxpal_pkg::op_t o, logic [15:0] c, logic l);
      logic [15:0] e;
      logic [4:0]  r;
      logic [4:0]  g;
      logic [4:0]  b;
      logic        a;
      pc_color_t   res;
      if (o == psxpal_pkg::OP_LOAD) begin
        useful_items++;
        if (ready) clear_palette();
        // a full store drops the entry but still honors last
        if (n_entries < PAL_DEPTH) begin
          entries[n_entries] = c;
          n_entries++;
          if (c == psxpal_pkg::BLACK_OPAQUE) saw_black = 1'b1;
          if (c[psxpal_pkg::STP_BIT]) any_stp = 1'b1;
          else all_stp = 1'b0;
        end
        if (l) begin
          if (mode[psxpal_pkg::MODE_TEST_BIT]) begin
            low_byte_alpha = 1'b1;
            argb           = saw_black;
          end else begin
            low_byte_alpha = 1'b0;
            argb           = any_stp && !all_stp && mode[psxpal_pkg::MODE_MIXED_BIT];
          end
          ready  = 1'b1;
          rd_ptr = 0;
        end
        return;
      end
      if (!ready || rd_ptr >= n_entries) return;
      useful_items++;
      e = entries[rd_ptr];
      r = e[4:0];
      g = e[9:5];
      b = e[14:10];
      a = low_byte_alpha ? (e[7:0] != 8'd0) : (e != 16'd0);
      res.color = argb ? {a, r, g, b} : {r, g, g[4], b};
      res.argb  = argb;
      res.last  = (rd_ptr + 1 == n_entries);
      expected_q.push_back(res);
      rd_ptr++;
      if (res.last) clear_palette();
    endfunction

    function void report(string what, logic [15:0] exp_v, logic [15:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("ERROR %0t: %s expected %h got %h", $time, what, exp_v, got_v);
    endfunction

    function void check_result(pc_color_t got);
      pc_color_t exp_r;
      if (expected_q.size() == 0) begin
        report("unexpected result, color_out", 16'h0, got.color);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.color !== exp_r.color) report("color_out", exp_r.color, got.color);
      if (got.argb !== exp_r.argb)
        report("alpha_format", 16'(exp_r.argb), 16'(got.argb));
      if (got.last !== exp_r.last)
        report("last_out", 16'(exp_r.last), 16'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [psxpal_pkg::MODE_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic [15:0]       color_in;
  logic              last_in;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       color_out;
  logic              alpha_format;
  logic              last_out;

  palette_scoreboard sb;
  bit                burst;
  bit                hold_req;
  int unsigned       cycles;

  psx_palette_to_pc_color uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .color_in     (color_in),
    .last_in      (last_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .color_out    (color_out),
    .alpha_format (alpha_format),
    .last_out     (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Monitors
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_item(psxpal_pkg::op_t'(op), color_in, last_in);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result({color_out, alpha_format, last_out});
  end

  // Receiver: random stall before each transaction, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      n = burst ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send_item(psxpal_pkg::op_t o, logic [15:0] c, logic l);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      op       <= 1'($urandom_range(0, 1));
      color_in <= 16'($urandom_range(0, 16'hFFFF));
      last_in  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    color_in <= c;
    last_in  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender idles until every expected result is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(logic [psxpal_pkg::MODE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= psxpal_pkg::MODE_W'($urandom_range(0, 31));
    sb.mode = v;
  endtask

  function automatic logic [15:0] pick_color(int style);
    logic [15:0] special [8];
    special = '{16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF,
                16'h8100, 16'hFF00, 16'h00FF, 16'h0001};
    case (style)
      0: return {1'b1, 15'($urandom_range(0, 16'h7FFF))};
      1: return {1'b0, 15'($urandom_range(0, 16'h7FFF))};
      2: return 16'($urandom_range(0, 16'hFFFF));
      default: return $urandom_range(0, 1) ? special[$urandom_range(0, 7)]
                                            : 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Loads beyond the store depth carry 0x8000 to show they leave the flags alone
  task automatic run_palette(int size, int style, bit close, int n_emit, bit hold);
    for (int i = 0; i < size; i++) begin
      send_item(psxpal_pkg::OP_LOAD,
                (i >= PAL_DEPTH) ? psxpal_pkg::BLACK_OPAQUE : pick_color(style),
                close && (i == size - 1));
    end
    if (hold) hold_req = 1'b1;
    repeat (n_emit)
      send_item(psxpal_pkg::OP_EMIT, 16'($urandom_range(0, 16'hFFFF)),
                1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [psxpal_pkg::MODE_W-1:0] modes [6];
    int size;
    int n_emit;
    modes = '{5'h00, 5'h1F, 5'h10, 5'h01, 5'h11, 5'h0E};
    sb          = new();
    cycles      = 0;
    burst       = 1'b0;
    hold_req    = 1'b0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    op          = psxpal_pkg::OP_LOAD;
    color_in    = '0;
    last_in     = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: emit with no palette, stp mixed, black-opaque test,
    // reload while ready, ignored mode bits, extra emit after the last one
    send_item(psxpal_pkg::OP_EMIT, 16'hFFFF, 1'b1);
    write_mode(5'h01);
    send_item(psxpal_pkg::OP_LOAD, 16'hFFFF, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'h0000, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'h8000, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'h7FFF, 1'b1);
    repeat (5) send_item(psxpal_pkg::OP_EMIT, 16'h0000, 1'b0);
    write_mode(5'h10);
    send_item(psxpal_pkg::OP_LOAD, 16'h8000, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'h00FF, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'hFF00, 1'b1);
    repeat (2) send_item(psxpal_pkg::OP_EMIT, 16'h0000, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'h1234, 1'b1);
    send_item(psxpal_pkg::OP_EMIT, 16'h0000, 1'b0);
    write_mode(5'h0E);
    send_item(psxpal_pkg::OP_LOAD, 16'h83E0, 1'b0);
    send_item(psxpal_pkg::OP_LOAD, 16'h801F, 1'b1);
    repeat (2) send_item(psxpal_pkg::OP_EMIT, 16'h0000, 1'b0);
    write_mode(5'h1F);
    send_item(psxpal_pkg::OP_LOAD, 16'h7C00, 1'b1);
    send_item(psxpal_pkg::OP_EMIT, 16'h0000, 1'b0);

    // Random palettes, leaving room for the overfill run at the end
    while (sb.useful_items < ITEM_TARGET - (PAL_DEPTH + 4 + OVERFILL_EMITS)) begin
      if ($urandom_range(0, 1))
        write_mode($urandom_range(0, 2) == 0 ? 5'($urandom_range(0, 31))
                                             : modes[$urandom_range(0, 5)]);
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        send_item(psxpal_pkg::OP_EMIT, 16'($urandom_range(0, 16'hFFFF)),
                  1'($urandom_range(0, 1)));
      size   = ($urandom_range(0, 24) == 0) ? $urandom_range(17, 40)
                                            : $urandom_range(1, 16);
      n_emit = size;
      case ($urandom_range(0, 5))
        0: n_emit = $urandom_range(0, size - 1);
        1: n_emit = size + $urandom_range(1, 3);
        default: ;
      endcase
      run_palette(size, $urandom_range(0, 3), $urandom_range(0, 7) != 0, n_emit, 1'b0);
    end

    // Overfilled store under a long output hold-off
    write_mode(5'h10);
    burst = 1'b1;
    run_palette(PAL_DEPTH + 4, 1, 1'b1, OVERFILL_EMITS, 1'b1);
    burst = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      sb.report("results never seen, count", 16'h0, 16'(sb.pending()));
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/psxpal_pkg.sv
rtl/psx_palette_to_pc_color.sv
verif/tb_top.sv
